>>> src/oal_pkg.sv
// shared constants and types for the ordered list engine
package oal_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 7;
  localparam int ID_W       = 16;
  localparam int PAY_W      = 32;
  localparam int ENTRY_W    = ID_W + PAY_W;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

endpackage

>>> src/ordered_array_list_engine.sv
// ordered list engine top level: sequencer plus entry memory
//
// Usage: a word is taken when start is high and busy is low. Its result is
// shown for exactly one cycle with done high, and the receiver cannot stall
// it. A rejected action (full list, bad position) gives its result in the
// next cycle without raising busy. Insert, delete and find run longer the
// more entries of the 64-entry list they must move or search, as the single
// read port of the entry memory moves or compares one entry per cycle. The
// list is empty after reset.
module ordered_array_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   action,
  input  logic [oal_pkg::POS_W-1:0]    position,
  input  logic [oal_pkg::ID_W-1:0]     key_id,
  input  logic [oal_pkg::PAY_W-1:0]    entry_payload,
  output logic                         busy,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [oal_pkg::ADDR_W-1:0]   found_position,
  output logic [oal_pkg::ID_W-1:0]     out_id,
  output logic [oal_pkg::PAY_W-1:0]    out_payload,
  output logic [oal_pkg::CNT_W-1:0]    entry_count
);

  oal_pkg::ram_req_t            mem_req;
  logic [oal_pkg::ENTRY_W-1:0]  mem_rdata;

  oal_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (action),
    .position       (position),
    .key_id         (key_id),
    .entry_payload  (entry_payload),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .out_id         (out_id),
    .out_payload    (out_payload),
    .entry_count    (entry_count),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  oal_ram #(
    .WIDTH (oal_pkg::ENTRY_W),
    .DEPTH (oal_pkg::LIST_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> busy)
    else $error("entry memory written while idle");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != oal_pkg::ST_OK) |->
      (found_position == '0 && out_id == '0 && out_payload == '0))
    else $error("failed action returned nonzero fields");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= oal_pkg::CNT_W'(oal_pkg::LIST_DEPTH))
    else $error("entry count beyond list depth");
`endif

endmodule

>>> src/oal_ram.sv
// generic single-write, single-read ram with registered read data
module oal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/oal_ctrl.sv
// action sequencer: shifts, searches and reads the entry memory
module oal_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   action,
  input  logic [oal_pkg::POS_W-1:0]    position,
  input  logic [oal_pkg::ID_W-1:0]     key_id,
  input  logic [oal_pkg::PAY_W-1:0]    entry_payload,
  output logic                         busy,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [oal_pkg::ADDR_W-1:0]   found_position,
  output logic [oal_pkg::ID_W-1:0]     out_id,
  output logic [oal_pkg::PAY_W-1:0]    out_payload,
  output logic [oal_pkg::CNT_W-1:0]    entry_count,
  output oal_pkg::ram_req_t            mem_req,
  input  logic [oal_pkg::ENTRY_W-1:0]  mem_rdata
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS       = 3'd1;
  localparam logic [2:0] S_DEL       = 3'd2;
  localparam logic [2:0] S_FIND      = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;
  localparam logic [2:0] S_READ_WAIT = 3'd5;

  localparam int AW = oal_pkg::ADDR_W;
  localparam int CW = oal_pkg::CNT_W;

  logic [2:0]                  state, state_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [CW-1:0]               cur, cur_next;
  logic [oal_pkg::POS_W-1:0]   pos_r, pos_r_next;
  logic [oal_pkg::ID_W-1:0]    key_r, key_r_next;
  logic [oal_pkg::PAY_W-1:0]   pay_r, pay_r_next;
  logic                        rd_pend, rd_pend_next;
  logic                        cap_pend, cap_pend_next;
  logic [AW-1:0]               tag, tag_next;
  logic [oal_pkg::ID_W-1:0]    hold_id, hold_id_next;
  logic [oal_pkg::PAY_W-1:0]   hold_pay, hold_pay_next;
  logic                        done_next;
  logic [1:0]                  status_next;
  logic [AW-1:0]               found_position_next;
  logic [oal_pkg::ID_W-1:0]    out_id_next;
  logic [oal_pkg::PAY_W-1:0]   out_payload_next;
  logic [CW-1:0]               entry_count_next;
  logic [oal_pkg::ID_W-1:0]    rd_id;
  logic [oal_pkg::PAY_W-1:0]   rd_pay;

  assign rd_id  = mem_rdata[oal_pkg::ENTRY_W-1 -: oal_pkg::ID_W];
  assign rd_pay = mem_rdata[oal_pkg::PAY_W-1:0];
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next          = state;
    cnt_next            = cnt;
    cur_next            = cur;
    pos_r_next          = pos_r;
    key_r_next          = key_r;
    pay_r_next          = pay_r;
    rd_pend_next        = rd_pend;
    cap_pend_next       = cap_pend;
    tag_next            = tag;
    hold_id_next        = hold_id;
    hold_pay_next       = hold_pay;
    done_next           = 1'b0;
    status_next         = status;
    found_position_next = found_position;
    out_id_next         = out_id;
    out_payload_next    = out_payload;
    entry_count_next    = entry_count;
    mem_req.we          = 1'b0;
    mem_req.waddr       = tag;
    mem_req.wdata       = mem_rdata;
    mem_req.raddr       = cur[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          pos_r_next          = position;
          key_r_next          = key_id;
          pay_r_next          = entry_payload;
          rd_pend_next        = 1'b0;
          cap_pend_next       = 1'b0;
          status_next         = oal_pkg::ST_BADPOS;
          found_position_next = '0;
          out_id_next         = '0;
          out_payload_next    = '0;
          entry_count_next    = cnt;
          unique case (action)
            oal_pkg::ACT_INSERT: begin
              if (cnt == CW'(oal_pkg::LIST_DEPTH)) begin
                status_next = oal_pkg::ST_FULL;
                done_next   = 1'b1;
              end else if (position > cnt) begin
                done_next = 1'b1;
              end else begin
                cur_next   = cnt;
                state_next = S_INS;
              end
            end
            oal_pkg::ACT_DELETE: begin
              if (position >= cnt) begin
                done_next = 1'b1;
              end else begin
                cur_next   = CW'(position);
                state_next = S_DEL;
              end
            end
            oal_pkg::ACT_FIND: begin
              cur_next   = '0;
              state_next = S_FIND;
            end
            oal_pkg::ACT_READ: begin
              if (position >= cnt) begin
                done_next = 1'b1;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // move entry cur-1 up to cur, then drop the new entry in at pos
        if (rd_pend) begin
          mem_req.we = 1'b1;
        end
        if (cur > pos_r) begin
          mem_req.raddr = AW'(cur - CW'(1));
          rd_pend_next  = 1'b1;
          tag_next      = cur[AW-1:0];
          cur_next      = cur - CW'(1);
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = pos_r[AW-1:0];
            mem_req.wdata       = {key_r, pay_r};
            cnt_next            = cnt + CW'(1);
            done_next           = 1'b1;
            status_next         = oal_pkg::ST_OK;
            found_position_next = pos_r[AW-1:0];
            entry_count_next    = cnt + CW'(1);
            state_next          = S_IDLE;
          end
        end
      end

      S_DEL: begin
        // first read captures the removed entry, later reads move down one
        if (rd_pend) begin
          if (cap_pend) begin
            hold_id_next  = rd_id;
            hold_pay_next = rd_pay;
          end else begin
            mem_req.we = 1'b1;
          end
        end
        if (cur < cnt) begin
          mem_req.raddr = cur[AW-1:0];
          rd_pend_next  = 1'b1;
          cap_pend_next = (cur == pos_r);
          tag_next      = AW'(cur - CW'(1));
          cur_next      = cur + CW'(1);
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            cnt_next            = cnt - CW'(1);
            done_next           = 1'b1;
            status_next         = oal_pkg::ST_OK;
            found_position_next = pos_r[AW-1:0];
            out_id_next         = hold_id;
            out_payload_next    = hold_pay;
            entry_count_next    = cnt - CW'(1);
            state_next          = S_IDLE;
          end
        end
      end

      S_FIND: begin
        if (rd_pend && (rd_id == key_r)) begin
          rd_pend_next        = 1'b0;
          done_next           = 1'b1;
          status_next         = oal_pkg::ST_OK;
          found_position_next = tag;
          state_next          = S_IDLE;
        end else if (cur < cnt) begin
          mem_req.raddr = cur[AW-1:0];
          rd_pend_next  = 1'b1;
          tag_next      = cur[AW-1:0];
          cur_next      = cur + CW'(1);
        end else if (!rd_pend) begin
          done_next   = 1'b1;
          status_next = oal_pkg::ST_NOTFOUND;
          state_next  = S_IDLE;
        end else begin
          rd_pend_next = 1'b0;
        end
      end

      S_READ: begin
        mem_req.raddr = pos_r[AW-1:0];
        state_next    = S_READ_WAIT;
      end

      S_READ_WAIT: begin
        done_next           = 1'b1;
        status_next         = oal_pkg::ST_OK;
        found_position_next = pos_r[AW-1:0];
        out_id_next         = rd_id;
        out_payload_next    = rd_pay;
        state_next          = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rd_pend  <= 1'b0;
      cap_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_pend  <= rd_pend_next;
      cap_pend <= cap_pend_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur            <= cur_next;
    pos_r          <= pos_r_next;
    key_r          <= key_r_next;
    pay_r          <= pay_r_next;
    tag            <= tag_next;
    hold_id        <= hold_id_next;
    hold_pay       <= hold_pay_next;
    status         <= status_next;
    found_position <= found_position_next;
    out_id         <= out_id_next;
    out_payload    <= out_payload_next;
    entry_count    <= entry_count_next;
  end

endmodule
